// File: hw/rtl/rc4h_pkg.sv
// ----------------------------------------------------------------------------
// RC4 keystream with hash reseed: shared definitions
// Constants and types used by the modules of the keystream block.
// ----------------------------------------------------------------------------
package rc4h_pkg;

  localparam int unsigned PermDepth = 256;
  localparam int unsigned PermAw    = 8;
  localparam int unsigned KeyLen    = 8;
  localparam int unsigned TopShift  = 22;
  localparam int unsigned HashW     = 30;

  localparam logic [29:0] HashMult = 30'd425481007;
  localparam logic [29:0] HashMod  = 30'd1000000007;

  // Twice the modulus, for the final correction of the reduction unit.
  localparam logic [31:0] HashModX2 = {1'b0, HashMod, 1'b0};

  // Residues of 2^30 and 2^60, used to fold a 64-bit magnitude down.
  localparam logic [26:0] Fold30 = 27'((64'd1 << 30) % 64'(HashMod));
  localparam logic [29:0] Fold60 = 30'((64'(Fold30) * 64'(Fold30)) % 64'(HashMod));

  // Reciprocal of the modulus scaled by 2^57, for the quotient estimate.
  localparam logic [27:0] BarrettMu = 28'((64'd1 << 57) / 64'(HashMod));

  typedef enum logic [0:0] {
    OpDecode = 1'b0,
    OpAbsorb = 1'b1
  } op_e;

  // Request from the controller to the modular reduction unit.
  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } red_req_t;

  // Reply of the reduction unit.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [29:0] residue;
  } red_rsp_t;

endpackage

// File: hw/rtl/rc4h_perm_ram.sv
// ----------------------------------------------------------------------------
// RC4 permutation memory
// Single-port synchronous RAM, 256 x 8, with a registered read.
// ----------------------------------------------------------------------------
module rc4h_perm_ram (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] addr_i,
  input  logic [7:0] wdata_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [256];

  // Write or read one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: hw/rtl/rc4h_modred.sv
// ----------------------------------------------------------------------------
// RC4 hash reduction unit
// Computes the non-negative residue of a signed 64-bit value modulo the hash
// modulus by fold, quotient estimate, remainder and correction, in that order.
// ----------------------------------------------------------------------------
module rc4h_modred (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rc4h_pkg::red_req_t  req_i,
  output rc4h_pkg::red_rsp_t  rsp_o
);
  import rc4h_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [1:0]  stage_q, stage_d;
  logic        neg_q, neg_d;
  logic [63:0] mag_q, mag_d;
  logic [56:0] fold_q, fold_d;
  logic [27:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [29:0] res_q, res_d;
  logic [56:0] fold;
  logic [55:0] quot_full;
  logic [31:0] qm_low;
  logic [31:0] rem_one;
  logic [29:0] fixed;

  // Replace the weights 2^30 and 2^60 by their residues; the sum stays
  // below 2^57.
  assign fold = 57'(mag_q[59:30]) * 57'(Fold30) + 57'(mag_q[63:60]) * 57'(Fold60)
              + 57'(mag_q[29:0]);

  // Quotient estimate, at most two below the true quotient.
  assign quot_full = 56'(fold_q[56:29]) * 56'(BarrettMu);

  // The remainder is below three moduli, so the low 32 bits are enough.
  assign qm_low = 32'(quot_q) * 32'(HashMod);

  // Bring the remainder into range, then apply the sign.
  always_comb begin
    if (rem_q >= HashModX2) begin
      rem_one = rem_q - HashModX2;
    end else if (rem_q >= {2'b00, HashMod}) begin
      rem_one = rem_q - {2'b00, HashMod};
    end else begin
      rem_one = rem_q;
    end
    if (neg_q && (rem_one != 32'd0)) begin
      fixed = HashMod - rem_one[29:0];
    end else begin
      fixed = rem_one[29:0];
    end
  end

  // Capture the magnitude, then step through the four stages.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    stage_d = stage_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    fold_d  = fold_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    res_d   = res_q;
    if (req_i.start && !busy_q) begin
      busy_d  = 1'b1;
      stage_d = 2'd0;
      neg_d   = req_i.operand[63];
      mag_d   = req_i.operand[63] ? (64'd0 - req_i.operand) : req_i.operand;
    end else if (busy_q) begin
      stage_d = stage_q + 2'd1;
      unique case (stage_q)
        2'd0: fold_d = fold;
        2'd1: quot_d = quot_full[55:28];
        2'd2: rem_d  = fold_q[31:0] - qm_low;
        2'd3: begin
          res_d  = fixed;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      stage_q <= 2'd0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    fold_q <= fold_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.residue = res_q;

endmodule

// File: hw/rtl/rc4_keystream_with_hash_reseed.sv
// ----------------------------------------------------------------------------
// RC4 keystream with hash reseed
// Top level: controller around the permutation RAM and hash reduction unit.
// ----------------------------------------------------------------------------
// Usage:
// Input channel in_valid_i/in_ready_o carries operation_i and value_i. A
// decode transfer returns one decoded_word_o on the out_valid_o/out_ready_i
// channel; an absorb transfer returns nothing.
// Decode walks four keystream steps on the single-port permutation RAM, each
// a swap of S[i] and S[j] followed by the read of the output byte. The result
// enters the output register from StResp, and no new item is taken until the
// block is back in idle.
// An absorb reduces the value and then the new hash in the four-stage
// reduction unit, then reruns the key schedule: a refill of the identity
// into all 256 entries and then the 256 swap steps. The next item is taken
// only once the schedule is done.
// After reset the block runs the schedule with a zero key and holds
// in_ready_o low until it is done.
// The output register lets the controller go on while the receiver stalls; a
// decode that finishes while the register is still full waits for it, and no
// new item is taken meanwhile.
// ----------------------------------------------------------------------------
module rc4_keystream_with_hash_reseed (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [0:0]         operation_i,
  input  logic signed [63:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] decoded_word_o
);
  import rc4h_pkg::*;

  typedef enum logic [13:0] {
    StIdle  = 14'b00000000000001,
    StFill  = 14'b00000000000010,
    StKsRdI = 14'b00000000000100,
    StKsWtI = 14'b00000000001000,
    StKsRdJ = 14'b00000000010000,
    StKsWrI = 14'b00000000100000,
    StKsWrJ = 14'b00000001000000,
    StMul   = 14'b00000010000000,
    StRed   = 14'b00000100000000,
    StKsOut = 14'b00001000000000,
    StOutWt = 14'b00010000000000,
    StResp  = 14'b00100000000000,
    StMul2  = 14'b01000000000000,
    StRed2  = 14'b10000000000000
  } state_e;

  state_e      state_q, state_d;
  logic        sched_q, sched_d;   // swap loop belongs to the key schedule
  logic [7:0]  i_q, i_d;
  logic [7:0]  j_q, j_d;
  logic [7:0]  n_q, n_d;           // schedule index
  logic [8:0]  cnt_q, cnt_d;       // fill counter and keystream byte count
  logic [7:0]  si_q, si_d;
  logic [7:0]  sj_q, sj_d;
  logic [29:0] hash_q, hash_d;
  logic [31:0] count_q, count_d;
  logic [31:0] word_q, word_d;
  logic [59:0] prod_q, prod_d;
  logic [63:0] val_q, val_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;

  logic        we;
  logic [7:0]  addr, wdata, rdata;
  red_req_t    red_req;
  red_rsp_t    red_rsp;
  logic [7:0]  key_byte;
  logic [7:0]  idx_a;
  logic [7:0]  j_new;
  logic [4:0]  shamt;

  rc4h_perm_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  rc4h_modred u_red (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (red_req),
    .rsp_o (red_rsp)
  );

  // Key byte for the current schedule index.
  always_comb begin
    unique case (n_q[2:0])
      3'd0: key_byte = hash_q[7:0];
      3'd1: key_byte = hash_q[15:8];
      3'd2: key_byte = hash_q[23:16];
      3'd3: key_byte = {2'b00, hash_q[29:24]};
      3'd4: key_byte = count_q[7:0];
      3'd5: key_byte = count_q[15:8];
      3'd6: key_byte = count_q[23:16];
      default: key_byte = count_q[31:24];
    endcase
  end

  assign idx_a = sched_q ? n_q : i_q;
  assign j_new = sched_q ? (j_q + rdata + key_byte) : (j_q + rdata);
  assign shamt = (cnt_q[1:0] == 2'd3) ? 5'(TopShift) : {cnt_q[1:0], 3'b000};

  // Sequencer: fill, swap steps, keystream output and hash update.
  always_comb begin
    state_d = state_q;
    sched_d = sched_q;
    i_d     = i_q;
    j_d     = j_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    si_d    = si_q;
    sj_d    = sj_q;
    hash_d  = hash_q;
    count_d = count_q;
    word_d  = word_q;
    prod_d  = prod_q;
    val_d   = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    we      = 1'b0;
    addr    = idx_a;
    wdata   = 8'd0;
    red_req.start   = 1'b0;
    red_req.operand = val_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i == OpAbsorb) begin
            val_d   = value_i;
            prod_d  = 60'(hash_q) * 60'(HashMult);
            state_d = StMul;
          end else begin
            word_d  = value_i[31:0];
            cnt_d   = 9'd0;
            sched_d = 1'b0;
            i_d     = i_q + 8'd1;
            state_d = StKsRdI;
          end
        end
      end
      // Reduce the absorbed value first.
      StMul: begin
        red_req.start = 1'b1;
        state_d = StRed;
      end
      StRed: begin
        if (red_rsp.done) begin
          val_d   = 64'(prod_q) + 64'(red_rsp.residue);
          state_d = StMul2;
        end
      end
      // Then reduce the hash product plus that residue.
      StMul2: begin
        red_req.start = 1'b1;
        state_d = StRed2;
      end
      StRed2: begin
        if (red_rsp.done) begin
          hash_d  = red_rsp.residue;
          count_d = count_q + 32'd1;
          cnt_d   = 9'd0;
          state_d = StFill;
        end
      end
      StFill: begin
        we      = 1'b1;
        addr    = cnt_q[7:0];
        wdata   = cnt_q[7:0];
        cnt_d   = cnt_q + 9'd1;
        if (cnt_q == 9'd255) begin
          sched_d = 1'b1;
          n_d     = 8'd0;
          j_d     = 8'd0;
          state_d = StKsRdI;
        end
      end
      StKsRdI: begin
        addr    = idx_a;
        state_d = StKsWtI;
      end
      StKsWtI: begin
        si_d    = rdata;
        j_d     = j_new;
        addr    = j_new;
        state_d = StKsRdJ;
      end
      StKsRdJ: begin
        addr    = j_q;
        state_d = StKsWrI;
      end
      StKsWrI: begin
        sj_d    = rdata;
        we      = 1'b1;
        addr    = idx_a;
        wdata   = rdata;
        state_d = StKsWrJ;
      end
      StKsWrJ: begin
        we      = 1'b1;
        addr    = j_q;
        wdata   = si_q;
        if (sched_q) begin
          n_d = n_q + 8'd1;
          if (n_q == 8'd255) begin
            sched_d = 1'b0;
            i_d     = 8'd0;
            j_d     = 8'd0;
            state_d = StIdle;
          end else begin
            state_d = StKsRdI;
          end
        end else begin
          state_d = StKsOut;
        end
      end
      StKsOut: begin
        addr    = si_q + sj_q;
        state_d = StOutWt;
      end
      StOutWt: begin
        word_d = word_q ^ (32'(rdata) << shamt);
        cnt_d  = cnt_q + 9'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = StResp;
        end else begin
          i_d     = i_q + 8'd1;
          state_d = StKsRdI;
        end
      end
      // Hand the word to the output register once it is free.
      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_word_d  = word_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StFill;
      sched_q     <= 1'b0;
      i_q         <= 8'd0;
      j_q         <= 8'd0;
      n_q         <= 8'd0;
      cnt_q       <= 9'd0;
      hash_q      <= 30'd0;
      count_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sched_q     <= sched_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      hash_q      <= hash_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    word_q     <= word_d;
    prod_q     <= prod_d;
    val_q      <= val_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o    = out_valid_q;
  assign decoded_word_o = out_word_q;

  // The hash always stays a proper residue.
  a_hash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_q < HashMod) else $error("hash out of range");

  // Input is only taken while idle.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle)) else $error("ready outside idle");

  // A result, once shown, holds until transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(decoded_word_o))
    else $error("result dropped");

  // The absorb count moves only on completion of the reduction.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(red_rsp.done)) else $error("count stepped");

endmodule

// File: tb/rc4h_checker.sv
// ----------------------------------------------------------------------------
// RC4 keystream checker
// Watches both channels, predicts each decoded word and compares it.
// ----------------------------------------------------------------------------
module rc4h_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [0:0]         operation_i,
  input  logic signed [63:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] decoded_word_i,
  output int                 fail_count_o,
  output int                 words_pending_o
);
  import rc4h_pkg::*;

  logic [7:0]  sbox [PermDepth];
  logic [7:0]  ks_i, ks_j;
  logic [29:0] hash_q;
  logic [31:0] absorbs_q;

  // Predicted words in order, kept in a small ring.
  logic [31:0] exp_mem [16];
  logic [3:0]  exp_wr, exp_rd;
  int          exp_count;

  // Rebuild the permutation from the hash and absorb counter.
  function automatic void rekey();
    logic [7:0] key [KeyLen];
    logic [7:0] j, t;
    j = '0;
    for (int n = 0; n < 4; n++) begin
      key[n]     = 8'(hash_q >> (8 * n));
      key[n + 4] = 8'(absorbs_q >> (8 * n));
    end
    for (int n = 0; n < PermDepth; n++) sbox[n] = n[7:0];
    for (int n = 0; n < PermDepth; n++) begin
      j = j + sbox[n] + key[n % KeyLen];
      t = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
    end
    ks_i = '0;
    ks_j = '0;
  endfunction

  function automatic logic [7:0] next_byte();
    logic [7:0] t;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + sbox[ks_i];
    t = sbox[ks_i];
    sbox[ks_i] = sbox[ks_j];
    sbox[ks_j] = t;
    return sbox[8'(sbox[ks_i] + sbox[ks_j])];
  endfunction

  // Fold a signed value into the hash as a true non-negative residue.
  function automatic void absorb(logic signed [63:0] v);
    logic signed [127:0] acc;
    acc = (128'(hash_q) * 128'(HashMult)) % 128'(HashMod);
    acc = acc + (128'(v) % $signed(128'(HashMod)));
    acc = acc % $signed(128'(HashMod));
    if (acc < 0) acc = acc + $signed(128'(HashMod));
    hash_q    = acc[29:0];
    absorbs_q = absorbs_q + 32'd1;
    rekey();
  endfunction

  function automatic logic [31:0] decode(logic [31:0] w);
    w ^= 32'(next_byte());
    w ^= 32'(next_byte()) << 8;
    w ^= 32'(next_byte()) << 16;
    w ^= 32'(next_byte()) << TopShift;
    return w;
  endfunction

  assign words_pending_o = exp_count;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q = '0;
      absorbs_q = '0;
      rekey();
      exp_wr = '0;
      exp_rd = '0;
      exp_count = 0;
      fail_count_o <= 0;
    end else begin
      // Compare an output transfer against the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (exp_count == 0) begin
          if (fail_count_o < 10) $display("unexpected word %h", decoded_word_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (exp_mem[exp_rd] !== decoded_word_i) begin
            if (fail_count_o < 10)
              $display("word mismatch: expected %h actual %h",
                       exp_mem[exp_rd], decoded_word_i);
            fail_count_o <= fail_count_o + 1;
          end
          exp_rd = exp_rd + 4'd1;
          exp_count = exp_count - 1;
        end
      end
      // Predict on each input transfer.
      if (in_valid_i && in_ready_i) begin
        if (op_e'(operation_i) == OpDecode) begin
          exp_mem[exp_wr] = decode(value_i[31:0]);
          exp_wr = exp_wr + 4'd1;
          exp_count = exp_count + 1;
        end else begin
          absorb(value_i);
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// RC4 keystream testbench top
// Drives decode and absorb items with bursty traffic and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import rc4h_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [0:0]         operation = OpDecode;
  logic signed [63:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] decoded_word;
  int                 fail_count, words_pending;
  int                 idle_cycles = 0;
  bit                 stim_done = 1'b0;
  bit                 long_hold = 1'b0;

  always #5 clk_i = ~clk_i;

  rc4_keystream_with_hash_reseed u_top (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .value_i(value), .out_valid_o(out_valid),
    .out_ready_i(out_ready), .decoded_word_o(decoded_word)
  );

  rc4h_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(operation), .value_i(value), .out_valid_i(out_valid),
    .out_ready_i(out_ready), .decoded_word_i(decoded_word),
    .fail_count_o(fail_count), .words_pending_o(words_pending)
  );

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(op_e op, logic [63:0] v);
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    do @(posedge clk_i); while (!(in_valid && in_ready));
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver stall pattern, with one long hold-off while items keep coming.
  initial begin
    int mode;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 3) != 0;
        default: out_ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // Stimulus: directed corners, then bursts of random items.
  initial begin
    int burst;
    int sent;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(OpDecode, 64'h0);
    send_item(OpDecode, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OpDecode, 64'hA5A5_A5A5_0000_0000);
    send_item(OpDecode, 64'h0000_0000_8000_0000);
    send_item(OpAbsorb, 64'h0);
    send_item(OpDecode, 64'h7FFF_FFFF);
    send_item(OpAbsorb, 64'h8000_0000_0000_0000);
    send_item(OpDecode, 64'h1234_5678);
    send_item(OpAbsorb, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OpAbsorb, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OpAbsorb, 64'd1000000007);
    send_item(OpAbsorb, -64'sd1000000007);
    send_item(OpDecode, 64'h5555_5555_AAAA_AAAA);
    pause(3);
    long_hold = 1'b1;
    for (int k = 0; k < 10; k++) send_item(OpDecode, rand64());
    sent = 0;
    while (sent < 430) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        // Absorbs are slow, so keep them rare.
        if ($urandom_range(0, 15) == 0) send_item(OpAbsorb, rand64());
        else send_item(OpDecode, rand64());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 20));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Watchdog and end of run.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("rc4_keystream_with_hash_reseed test failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done && words_pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && words_pending == 0)
      $display("rc4_keystream_with_hash_reseed test passed");
    else
      $display("rc4_keystream_with_hash_reseed test failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rc4h_pkg.sv
hw/rtl/rc4h_perm_ram.sv
hw/rtl/rc4h_modred.sv
hw/rtl/rc4_keystream_with_hash_reseed.sv
tb/rc4h_checker.sv
tb/tb_top.sv
